### rtl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; every other file refers to this package by scoped names.
package fpa_pkg;

  localparam int WordBits  = 32;
  localparam int FracBits  = 8;
  localparam int DivSteps  = WordBits + FracBits;
  localparam int ProdBits  = 2 * WordBits;
  localparam int NumStages = DivSteps + 3;

  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_GT       = 4'd4,
    KIND_LT       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_LE       = 4'd7,
    KIND_EQ       = 4'd8,
    KIND_NE       = 4'd9,
    KIND_MIN      = 4'd10,
    KIND_MAX      = 4'd11,
    KIND_INC      = 4'd12,
    KIND_DEC      = 4'd13,
    KIND_FROM_INT = 4'd14,
    KIND_TO_INT   = 4'd15
  } kind_e;

  typedef struct packed {
    logic [3:0]          kind;
    logic signed [31:0]  operand_a;
    logic signed [31:0]  operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  result_value;
    logic                condition;
    logic                overflow;
    logic                divide_by_zero;
  } out_t;

  // classified transaction handed from the front end to the execution pipe
  typedef struct packed {
    kind_e                kind;
    logic [WordBits-1:0]  a;
    logic [WordBits-1:0]  b;
    logic [WordBits-1:0]  mag_a;
    logic [WordBits-1:0]  mag_b;
    logic                 neg;
  } job_t;

  typedef struct packed {
    kind_e                kind;
    logic                 neg;
    logic                 cond;
    logic                 ovf;
    logic                 dbz;
    logic [WordBits-1:0]  val;
    logic [WordBits-1:0]  rem;
    logic [ProdBits-1:0]  acc;
    logic [WordBits-1:0]  dvs;
  } stage_t;

endpackage

### rtl/fpa_front.sv
// Front end: input register that accepts transactions and classifies them.
// Uses fpa_pkg types; feeds fpa_queue.
module fpa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fpa_pkg::in_t  in_data_i,
  output logic          job_valid_o,
  input  logic          job_full_i,
  output fpa_pkg::job_t job_o
);

  logic          vld_q;
  fpa_pkg::job_t job_q, job_d;
  logic          take;

  assign in_stall_o  = vld_q && job_full_i;
  assign take        = in_valid_i && !in_stall_o;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  always_comb begin
    job_d.kind  = fpa_pkg::kind_e'(in_data_i.kind);
    job_d.a     = in_data_i.operand_a;
    job_d.b     = in_data_i.operand_b;
    job_d.mag_a = in_data_i.operand_a[31] ? (~job_d.a + 32'd1) : job_d.a;
    job_d.mag_b = in_data_i.operand_b[31] ? (~job_d.b + 32'd1) : job_d.b;
    job_d.neg   = in_data_i.operand_a[31] ^ in_data_i.operand_b[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (!job_full_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_d;
    end
  end

endmodule

### rtl/fpa_queue.sv
// Two-entry queue that decouples the front end from the execution pipe.
// Uses fpa_pkg::job_t.
module fpa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fpa_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output fpa_pkg::job_t head_o
);

  fpa_pkg::job_t mem_q [2];
  logic [1:0]    cnt_q;
  logic          wr_q;
  logic          rd_q;
  logic          do_push;
  logic          do_pop;

  assign full_o       = cnt_q[1];
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### rtl/fpa_back.sv
// Execution pipe: simple ops and the multiply in the first stage, one quotient
// bit per stage for divide, then rounding and wrap. Uses fpa_pkg.
module fpa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  fpa_pkg::job_t  head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fpa_pkg::out_t  out_data_o
);

  localparam int Last = fpa_pkg::NumStages - 1;
  localparam int Rnd  = fpa_pkg::DivSteps + 1;
  localparam int Ds   = fpa_pkg::DivSteps;
  localparam int Wb   = fpa_pkg::WordBits;
  localparam int Fb   = fpa_pkg::FracBits;

  fpa_pkg::stage_t st_q [fpa_pkg::NumStages];
  fpa_pkg::stage_t st_d [fpa_pkg::NumStages];
  logic [fpa_pkg::NumStages-1:0] vld_q;
  logic en;

  // the whole pipe freezes only while a finished result is held back
  assign en    = !(vld_q[Last] && out_stall_i);
  assign pop_o = en && head_valid_i;

  // first stage
  logic [Wb-1:0] sum, dif, inc, dec;
  logic          lt, eq;
  always_comb begin
    sum = head_i.a + head_i.b;
    dif = head_i.a - head_i.b;
    inc = head_i.a + Wb'(1);
    dec = head_i.a - Wb'(1);
    lt  = $signed(head_i.a) < $signed(head_i.b);
    eq  = head_i.a == head_i.b;
    st_d[0].kind = head_i.kind;
    st_d[0].neg  = head_i.neg;
    st_d[0].cond = 1'b0;
    st_d[0].ovf  = 1'b0;
    st_d[0].dbz  = 1'b0;
    st_d[0].val  = '0;
    st_d[0].rem  = '0;
    st_d[0].acc  = '0;
    st_d[0].dvs  = head_i.mag_b;
    unique case (head_i.kind)
      fpa_pkg::KIND_ADD: begin
        st_d[0].val = sum;
        st_d[0].ovf = (head_i.a[Wb-1] == head_i.b[Wb-1]) && (sum[Wb-1] != head_i.a[Wb-1]);
      end
      fpa_pkg::KIND_SUB: begin
        st_d[0].val = dif;
        st_d[0].ovf = (head_i.a[Wb-1] != head_i.b[Wb-1]) && (dif[Wb-1] != head_i.a[Wb-1]);
      end
      fpa_pkg::KIND_MUL: st_d[0].acc = head_i.mag_a * head_i.mag_b;
      fpa_pkg::KIND_DIV: begin
        st_d[0].acc = {{(fpa_pkg::ProdBits - Ds){1'b0}}, head_i.mag_a, {Fb{1'b0}}};
        st_d[0].dbz = head_i.b == '0;
      end
      fpa_pkg::KIND_GT:  st_d[0].cond = !lt && !eq;
      fpa_pkg::KIND_LT:  st_d[0].cond = lt;
      fpa_pkg::KIND_GE:  st_d[0].cond = !lt;
      fpa_pkg::KIND_LE:  st_d[0].cond = lt || eq;
      fpa_pkg::KIND_EQ:  st_d[0].cond = eq;
      fpa_pkg::KIND_NE:  st_d[0].cond = !eq;
      fpa_pkg::KIND_MIN: st_d[0].val  = lt ? head_i.a : head_i.b;
      fpa_pkg::KIND_MAX: st_d[0].val  = lt ? head_i.b : head_i.a;
      fpa_pkg::KIND_INC: begin
        st_d[0].val = inc;
        st_d[0].ovf = !head_i.a[Wb-1] && inc[Wb-1];
      end
      fpa_pkg::KIND_DEC: begin
        st_d[0].val = dec;
        st_d[0].ovf = head_i.a[Wb-1] && !dec[Wb-1];
      end
      fpa_pkg::KIND_FROM_INT: begin
        st_d[0].val = head_i.a << Fb;
        // fits only when the bits shifted out all match the new sign
        st_d[0].ovf = !((&head_i.a[Wb-1:Wb-1-Fb]) || !(|head_i.a[Wb-1:Wb-1-Fb]));
      end
      fpa_pkg::KIND_TO_INT: st_d[0].val = Wb'($signed(head_i.a) >>> Fb);
      default: st_d[0].val = '0;
    endcase
  end

  // divide steps, one quotient bit each
  for (genvar k = 1; k <= Ds; k++) begin : g_div
    logic [Wb:0] trial;
    logic        ge;
    always_comb begin
      trial   = {st_q[k-1].rem, st_q[k-1].acc[Ds-1]};
      ge      = trial >= {1'b0, st_q[k-1].dvs};
      st_d[k] = st_q[k-1];
      if (st_q[k-1].kind == fpa_pkg::KIND_DIV) begin
        st_d[k].rem = ge ? Wb'(trial - {1'b0, st_q[k-1].dvs}) : trial[Wb-1:0];
        st_d[k].acc = {st_q[k-1].acc[fpa_pkg::ProdBits-1:Ds],
                       st_q[k-1].acc[Ds-2:0], ge};
      end
    end
  end

  // round half away from zero on the magnitude
  always_comb begin
    st_d[Rnd] = st_q[Ds];
    if (st_q[Ds].kind == fpa_pkg::KIND_DIV) begin
      st_d[Rnd].acc = fpa_pkg::ProdBits'(st_q[Ds].acc[Ds-1:0])
                    + fpa_pkg::ProdBits'({st_q[Ds].rem, 1'b0} >= {1'b0, st_q[Ds].dvs});
    end else if (st_q[Ds].kind == fpa_pkg::KIND_MUL) begin
      st_d[Rnd].acc = (st_q[Ds].acc + (fpa_pkg::ProdBits'(1) << (Fb - 1))) >> Fb;
    end
  end

  // apply sign, wrap and flag
  logic [fpa_pkg::ProdBits-1:0] limit;
  always_comb begin
    limit      = st_q[Rnd].neg ? (fpa_pkg::ProdBits'(1) << (Wb - 1))
                               : ((fpa_pkg::ProdBits'(1) << (Wb - 1)) - 1'b1);
    st_d[Last] = st_q[Rnd];
    if (st_q[Rnd].kind == fpa_pkg::KIND_MUL || st_q[Rnd].kind == fpa_pkg::KIND_DIV) begin
      if (st_q[Rnd].dbz) begin
        st_d[Last].val = '0;
        st_d[Last].ovf = 1'b0;
      end else begin
        st_d[Last].ovf = st_q[Rnd].acc > limit;
        st_d[Last].val = st_q[Rnd].neg ? (~st_q[Rnd].acc[Wb-1:0] + Wb'(1))
                                       : st_q[Rnd].acc[Wb-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Last-1:0], head_valid_i};
    end
  end

  for (genvar s = 0; s < fpa_pkg::NumStages; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign out_valid_o                 = vld_q[Last];
  assign out_data_o.result_value     = st_q[Last].val;
  assign out_data_o.condition        = st_q[Last].cond;
  assign out_data_o.overflow         = st_q[Last].ovf;
  assign out_data_o.divide_by_zero   = st_q[Last].dbz;

endmodule

### rtl/fixed_point_q24_8_alu_top.sv
// Top level of the Q24.8 fixed-point ALU: front end, queue and execution pipe.
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
//
// Usage: present a transaction (kind, operand_a, operand_b) on in_data_i with
// in_valid_i; it is taken on a rising edge where in_stall_o is low. Each
// transaction gives exactly one result on out_data_o, in order, taken on an
// edge where out_valid_o is high and out_stall_i is low.
// Throughput: one transaction per cycle for every operation while the receiver does not stall.
// Path from acceptance to out_valid_o: one input register, one queue slot,
// and a 43-stage execution pipe whose depth is set by the divider, which
// retires one quotient bit per stage over 40 bits, followed by a rounding
// stage and a sign/wrap stage (the output register).
// All operations run through the same pipe so results keep their order.
// Reset clears all valid state; no result is shown until fresh input arrives.
// While the receiver stalls, the result holds steady and the pipe freezes;
// the two-entry queue and input register then absorb up to three more
// transactions before in_stall_o rises.
module fixed_point_q24_8_alu_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fpa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fpa_pkg::out_t out_data_o
);

  logic          job_valid, q_full, head_valid, pop;
  fpa_pkg::job_t job, head;

  fpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_full_i  (q_full),
    .job_o       (job)
  );

  fpa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .push_data_i  (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  fpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

### rtl/fpa_checker.sv
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_q24_8_alu_top.
module fpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fpa_pkg::out_t out_data_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_cond_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.condition |->
      out_data_o.result_value == '0 && !out_data_o.overflow && !out_data_o.divide_by_zero)
    else $error("comparison result carries value or flags");

  a_dbz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |->
      out_data_o.result_value == '0 && !out_data_o.overflow)
    else $error("divide by zero gave nonzero result or overflow");

endmodule

bind fixed_point_q24_8_alu_top fpa_checker u_fpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
